// File: sv/smt_pkg.sv
// ============================================================================
// smt_pkg
// Shared types and constants of the sorted multiset table.
// ============================================================================
`default_nettype none

package smt_pkg;

  // Field widths of the request and result transfers.
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned DISTINCT_W = 5;
  localparam int unsigned TOTAL_W    = 20;

  // Configuration port geometry.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index of filter_limit (bit 2 of the byte address).
  localparam logic REG_FILTER_LIMIT = 1'b0;

  // Reset value of filter_limit.
  localparam logic [PDATA_W-1:0] FILTER_LIMIT_RST = 32'd10;

  // Largest occurrence count an entry can hold.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_FILTER = 2'd3
  } smt_req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_SATURATED = 2'd3
  } smt_status_t;

  // Request transfer.
  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
  } smt_in_t;

  // Result transfer.
  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [COUNT_W-1:0]    occurrences;
    logic [DISTINCT_W-1:0] distinct;
    logic [TOTAL_W-1:0]    total;
    logic                  empty_res;
  } smt_out_t;

  // One table entry as kept in the memory.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
  } smt_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT_UP,
    S_INS,
    S_SHIFT_DN,
    S_FIN
  } smt_state_t;

endpackage

`default_nettype wire

// File: sv/smt_cfg.sv
// ============================================================================
// smt_cfg
// APB-style register slave holding the filter_limit register.
// ============================================================================
`default_nettype none

module smt_cfg
  import smt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [PDATA_W-1:0] filter_limit
);

  logic [PDATA_W-1:0] limit_r;
  logic [PDATA_W-1:0] limit_nxt;
  logic               wr_xfer;

  // The slave never inserts wait states.
  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite;

  // Register write decode; the low two address bits are ignored.
  always_comb begin
    limit_nxt = limit_r;
    if (wr_xfer && (paddr[2] == REG_FILTER_LIMIT)) begin
      limit_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= FILTER_LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Read data mux.
  assign prdata       = (paddr[2] == REG_FILTER_LIMIT) ? limit_r : '0;
  assign filter_limit = limit_r;

endmodule

`default_nettype wire

// File: sv/sorted_multiset_table_top.sv
// ============================================================================
// sorted_multiset_table_top
// Sorted bag of signed values with occurrence counts, kept in one memory.
// ============================================================================
//
//   Channel   Ports                        Carries
//   --------  ---------------------------  ------------------------------------
//   request   in_valid, in_ready, in_data  req_type, value
//   result    out_valid, out_ready,        status, found, occurrences,
//             out_data                     distinct, total, empty_res
//   config    psel, penable, pwrite,       filter_limit at byte address 0
//             paddr, pwdata, prdata, pready
//
// A request scans the stored entries one per cycle, up to the stored count,
// and an insert or delete then shifts entries one per cycle, an insert
// placing its new entry last. The single read port of the entry memory sets
// this pace. Reset is synchronous; the table comes up empty and the memory
// needs no clearing. A request can be taken while a result still waits in
// the output register; the sequencer holds in its final state until that
// register is free.
// ============================================================================
`default_nettype none

module sorted_multiset_table_top
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire smt_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output smt_out_t                out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Configuration register.
  logic [PDATA_W-1:0] filter_limit;

  smt_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .filter_limit (filter_limit)
  );

  // Entry memory: one write port and one registered read port.
  smt_entry_t mem [CAPACITY];
  logic [AW-1:0] rd_addr;
  smt_entry_t    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  smt_entry_t    mem_wd;

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Control and table state.
  smt_state_t                state_r,  state_nxt;
  logic [CW-1:0]             dc_r,     dc_nxt;
  logic [TOTAL_W-1:0]        total_r,  total_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Per-request working registers.
  logic [1:0]                req_r,    req_nxt;
  logic signed [VALUE_W-1:0] val_r,    val_nxt;
  logic [AW-1:0]             idx_r,    idx_nxt;
  logic [CW-1:0]             pos_r,    pos_nxt;
  logic                      hit_r,    hit_nxt;
  logic [COUNT_W-1:0]        cnt_r,    cnt_nxt;
  logic [CW-1:0]             keep_r,   keep_nxt;
  logic [TOTAL_W-1:0]        sum_r,    sum_nxt;
  logic [1:0]                rsts_r,   rsts_nxt;
  logic                      rfound_r, rfound_nxt;
  logic [COUNT_W-1:0]        rocc_r,   rocc_nxt;
  smt_out_t                  out_data_r, out_data_nxt;

  logic in_xfer;
  logic scan_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign scan_last = (CW'(idx_r) == CW'(dc_r - 1'b1));

  // Sequencer: scan, decide, shift, place, report.
  always_comb begin
    state_nxt     = state_r;
    dc_nxt        = dc_r;
    total_nxt     = total_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    keep_nxt      = keep_r;
    sum_nxt       = sum_r;
    rsts_nxt      = rsts_r;
    rfound_nxt    = rfound_r;
    rocc_nxt      = rocc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = idx_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_xfer) begin
          req_nxt  = in_data.req_type;
          val_nxt  = in_data.value;
          idx_nxt  = '0;
          pos_nxt  = '0;
          hit_nxt  = 1'b0;
          cnt_nxt  = '0;
          keep_nxt = '0;
          sum_nxt  = '0;
          state_nxt = (dc_r == '0) ? S_EXEC : S_SCAN;
        end
      end

      // One entry compared per cycle while the next one is read.
      S_SCAN: begin
        rd_addr = idx_r + 1'b1;
        if (req_r == REQ_FILTER) begin
          if ($signed(rd_data_r.value) <= $signed(filter_limit)) begin
            keep_nxt = keep_r + 1'b1;
          end else begin
            sum_nxt = sum_r + TOTAL_W'(rd_data_r.count);
          end
          if (scan_last) begin
            state_nxt = S_EXEC;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if ($signed(rd_data_r.value) >= val_r) begin
          pos_nxt   = CW'(idx_r);
          hit_nxt   = (rd_data_r.value == val_r);
          cnt_nxt   = rd_data_r.count;
          state_nxt = S_EXEC;
        end else if (scan_last) begin
          pos_nxt   = dc_r;
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Apply the request to the located entry.
      S_EXEC: begin
        rsts_nxt   = STS_OK;
        rfound_nxt = 1'b0;
        rocc_nxt   = '0;
        state_nxt  = S_FIN;
        mem_wa     = pos_r[AW-1:0];
        mem_wd.value = val_r;
        case (req_r)
          REQ_ADD: begin
            if (hit_r) begin
              rfound_nxt = 1'b1;
              if (cnt_r == COUNT_MAX) begin
                rsts_nxt = STS_SATURATED;
                rocc_nxt = COUNT_MAX;
              end else begin
                mem_we       = 1'b1;
                mem_wd.count = cnt_r + 1'b1;
                total_nxt    = total_r + 1'b1;
                rocc_nxt     = cnt_r + 1'b1;
              end
            end else if (dc_r == CW'(CAPACITY)) begin
              rsts_nxt = STS_FULL;
            end else begin
              rocc_nxt  = COUNT_W'(1);
              total_nxt = total_r + 1'b1;
              if (pos_r == dc_r) begin
                mem_we       = 1'b1;
                mem_wd.count = COUNT_W'(1);
                dc_nxt       = dc_r + 1'b1;
              end else begin
                rd_addr   = AW'(dc_r - 1'b1);
                idx_nxt   = AW'(dc_r - 1'b1);
                state_nxt = S_SHIFT_UP;
              end
            end
          end
          REQ_REMOVE: begin
            if (!hit_r) begin
              rsts_nxt = STS_NOT_FOUND;
            end else begin
              rfound_nxt = 1'b1;
              rocc_nxt   = cnt_r - 1'b1;
              total_nxt  = total_r - 1'b1;
              if (cnt_r != COUNT_W'(1)) begin
                mem_we       = 1'b1;
                mem_wd.count = cnt_r - 1'b1;
              end else if (pos_r == CW'(dc_r - 1'b1)) begin
                dc_nxt = dc_r - 1'b1;
              end else begin
                rd_addr   = AW'(pos_r + 1'b1);
                idx_nxt   = AW'(pos_r + 1'b1);
                state_nxt = S_SHIFT_DN;
              end
            end
          end
          REQ_QUERY: begin
            if (hit_r) begin
              rfound_nxt = 1'b1;
              rocc_nxt   = cnt_r;
            end else begin
              rsts_nxt = STS_NOT_FOUND;
            end
          end
          default: begin
            // Filter: the kept entries form a prefix of the sorted table.
            dc_nxt    = keep_r;
            total_nxt = total_r - sum_r;
          end
        endcase
      end

      // Move entries one place up, from the top down to the insert point.
      S_SHIFT_UP: begin
        mem_we = 1'b1;
        mem_wa = idx_r + 1'b1;
        if (CW'(idx_r) == pos_r) begin
          state_nxt = S_INS;
        end else begin
          rd_addr = idx_r - 1'b1;
          idx_nxt = idx_r - 1'b1;
        end
      end

      // Place the new entry in the freed slot.
      S_INS: begin
        mem_we       = 1'b1;
        mem_wa       = pos_r[AW-1:0];
        mem_wd.value = val_r;
        mem_wd.count = COUNT_W'(1);
        dc_nxt       = dc_r + 1'b1;
        state_nxt    = S_FIN;
      end

      // Move entries one place down over the deleted one.
      S_SHIFT_DN: begin
        mem_we = 1'b1;
        mem_wa = idx_r - 1'b1;
        if (scan_last) begin
          dc_nxt    = dc_r - 1'b1;
          state_nxt = S_FIN;
        end else begin
          rd_addr = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status      = rsts_r;
          out_data_nxt.found       = rfound_r;
          out_data_nxt.occurrences = rocc_r;
          out_data_nxt.distinct    = DISTINCT_W'(dc_r);
          out_data_nxt.total       = total_r;
          out_data_nxt.empty_res   = (dc_r == '0);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table totals and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dc_r        <= dc_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    hit_r      <= hit_nxt;
    cnt_r      <= cnt_nxt;
    keep_r     <= keep_nxt;
    sum_r      <= sum_nxt;
    rsts_r     <= rsts_nxt;
    rfound_r   <= rfound_nxt;
    rocc_r     <= rocc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table never holds more entries than it has slots.
  a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= CW'(CAPACITY))
    else $error("distinct count exceeds capacity");

  // An empty table carries no occurrences.
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (dc_r == '0) |-> (total_r == '0))
    else $error("empty table with nonzero total");

  // Shifting up only happens with a free slot at the top.
  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_UP) |-> (dc_r < CW'(CAPACITY)))
    else $error("insert shift on a full table");

  // The memory is written only by the modifying states.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC || state_r == S_SHIFT_UP ||
                state_r == S_INS || state_r == S_SHIFT_DN))
    else $error("memory write outside a modifying state");

  // A filter never grows the table.
  a_filter_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && req_r == REQ_FILTER) |-> (keep_r <= dc_r))
    else $error("filter keeps more entries than stored");

endmodule

`default_nettype wire

// File: sim/smt_result_checker.sv
// ============================================================================
// smt_result_checker
// Predicts every result of the sorted multiset table and compares it.
// ============================================================================
// The checker watches the request, result and register ports. Each request
// transfer is run through a private copy of the table, and the outcome waits
// in order until the matching result transfer arrives. Register writes on the
// configuration port update the private copy of the filter limit.
// ============================================================================

module smt_result_checker
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  smt_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  smt_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PADDR_W-1:0] ADDR_FILTER_LIMIT = {REG_FILTER_LIMIT, 2'b00};
  localparam int MAX_REPORTS = 10;

  // Private copy of the table, kept in ascending order of value.
  logic signed [VALUE_W-1:0] tab_val [CAPACITY];
  logic [COUNT_W-1:0]        tab_cnt [CAPACITY];
  int                        n_distinct;
  logic [TOTAL_W-1:0]        sum_total;
  logic signed [VALUE_W-1:0] limit_q;

  // Results predicted for accepted requests, oldest first.
  smt_out_t predicted_results [$];

  // Applies one request to the private table and returns its result.
  function automatic smt_out_t apply_request(smt_in_t rq);
    smt_out_t r;
    int       slot;
    int       pos;
    r    = '0;
    slot = -1;
    if (rq.req_type != REQ_FILTER) begin
      for (int i = 0; i < n_distinct; i++) begin
        if (slot < 0 && tab_val[i] == rq.value) slot = i;
      end
    end
    case (rq.req_type)
      REQ_ADD: begin
        if (slot >= 0) begin
          r.found = 1'b1;
          if (tab_cnt[slot] == COUNT_MAX) begin
            // A saturated count refuses the add and leaves the table alone.
            r.status      = STS_SATURATED;
            r.occurrences = COUNT_MAX;
          end else begin
            tab_cnt[slot]++;
            sum_total++;
            r.occurrences = tab_cnt[slot];
          end
        end else if (n_distinct >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          // New value: open a gap at its sorted place.
          pos = 0;
          while (pos < n_distinct && $signed(tab_val[pos]) <= $signed(rq.value)) pos++;
          for (int i = n_distinct; i > pos; i--) begin
            tab_val[i] = tab_val[i-1];
            tab_cnt[i] = tab_cnt[i-1];
          end
          tab_val[pos] = rq.value;
          tab_cnt[pos] = 1;
          n_distinct++;
          sum_total++;
          r.occurrences = 1;
        end
      end
      REQ_REMOVE: begin
        if (slot < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          tab_cnt[slot]--;
          sum_total--;
          r.occurrences = tab_cnt[slot];
          if (tab_cnt[slot] == 0) begin
            // Last occurrence gone: close the gap.
            for (int i = slot; i + 1 < n_distinct; i++) begin
              tab_val[i] = tab_val[i+1];
              tab_cnt[i] = tab_cnt[i+1];
            end
            n_distinct--;
          end
        end
      end
      REQ_QUERY: begin
        if (slot < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.found       = 1'b1;
          r.occurrences = tab_cnt[slot];
        end
      end
      default: begin
        // The table is sorted, so the entries that stay form a prefix.
        pos = 0;
        while (pos < n_distinct && $signed(tab_val[pos]) <= $signed(limit_q)) pos++;
        for (int i = pos; i < n_distinct; i++) sum_total -= TOTAL_W'(tab_cnt[i]);
        n_distinct = pos;
      end
    endcase
    r.distinct  = DISTINCT_W'(n_distinct);
    r.total     = sum_total;
    r.empty_res = (n_distinct == 0);
    return r;
  endfunction

  // Check results first, then follow register writes and new requests.
  always @(posedge clk) begin
    smt_out_t want;
    if (!rst_n) begin
      n_distinct = 0;
      sum_total  = '0;
      limit_q    = FILTER_LIMIT_RST;
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("[%0t] result transfer with no request outstanding", $realtime);
          end
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data !== want) begin
            if (fail_count < MAX_REPORTS) begin
              $display("[%0t] result mismatch: expected sts=%0d found=%0d occ=%0d dist=%0d total=%0d empty=%0d",
                       $realtime, want.status, want.found, want.occurrences,
                       want.distinct, want.total, want.empty_res);
              $display("           actual: sts=%0d found=%0d occ=%0d dist=%0d total=%0d empty=%0d",
                       out_data.status, out_data.found, out_data.occurrences,
                       out_data.distinct, out_data.total, out_data.empty_res);
            end
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_FILTER_LIMIT) begin
        limit_q = pwdata;
      end
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_request(in_data));
      end
    end
    results_owed = predicted_results.size();
  end

endmodule

// File: sim/tb_sorted_multiset_table_top.sv
// ============================================================================
// tb_sorted_multiset_table_top
// Testbench of the sorted multiset table.
// ============================================================================
// Drives requests and register writes, stalls both channels at random and
// leaves prediction and comparison to the checker. A directed opening covers
// the edge values and every request kind; bursts of distinct adds overflow
// the table, a run of repeated adds piles up one count, and random traffic
// on a small value pool exercises the rest under several filter limits, the
// largest value among them.
// ============================================================================

module tb_sorted_multiset_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smt_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int DRAIN_TAIL     = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int POOL_SIZE      = 24;
  localparam int FILL_BURST     = 18;
  localparam int REPEAT_ADDS    = 24;

  localparam logic [PADDR_W-1:0] ADDR_FILTER_LIMIT = {REG_FILTER_LIMIT, 2'b00};
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  smt_in_t            in_data  = '0;
  logic               out_ready = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;

  logic               in_ready;
  logic               out_valid;
  smt_out_t           out_data;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 fail_count;
  int                 results_owed;
  int                 send_idle_pct = 25;
  int                 recv_idle_pct = 84;
  int                 idle_cycles   = 0;
  logic [VALUE_W-1:0] cur_limit     = FILTER_LIMIT_RST;

  sorted_multiset_table_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  smt_result_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  // 8 ns clock.
  always #4 clk = ~clk;

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Give up when no transfer has happened for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after its transfer.
  task automatic send_req(input smt_req_t kind, input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, value: v};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds off new requests until every outstanding result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_filter_limit(input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FILTER_LIMIT;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_limit = v;
  endtask

  // Random traffic: mostly requests on a small pool so values hit, some
  // bursts of distinct adds that overflow the table, and some raw noise.
  task automatic random_chunk(input int n_items);
    logic [VALUE_W-1:0] pool [POOL_SIZE];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] stride;
    int                 sent;
    int                 pick;
    smt_req_t           kind;
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    pool[2] = '0;
    pool[3] = '1;
    for (int i = 4; i < 14; i++) pool[i] = cur_limit + i - 9;
    for (int i = 14; i < POOL_SIZE; i++) pool[i] = $urandom;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (sent == 0 || pick < 2) begin
        base   = $urandom;
        stride = $urandom_range(1, 1000);
        for (int i = 0; i < FILL_BURST; i++) send_req(REQ_ADD, base + i * stride);
        sent += FILL_BURST;
      end else if (pick < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) kind = REQ_ADD;
        else if (pick < 70) kind = REQ_REMOVE;
        else if (pick < 92) kind = REQ_QUERY;
        else kind = REQ_FILTER;
        send_req(kind, pool[$urandom_range(0, POOL_SIZE - 1)]);
        sent++;
      end else begin
        send_req(smt_req_t'($urandom_range(0, 3)), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender idles a quarter of the time, receiver mostly stalls.
    write_filter_limit(FILTER_LIMIT_RST);

    // Empty table, then the extremes, duplicates, deletes and a filter.
    send_req(REQ_QUERY, 32'd5);
    send_req(REQ_REMOVE, 32'd5);
    send_req(REQ_FILTER, '0);
    send_req(REQ_ADD, VAL_MAX);
    send_req(REQ_ADD, VAL_MIN);
    send_req(REQ_ADD, '0);
    send_req(REQ_ADD, '0);
    send_req(REQ_ADD, '1);
    send_req(REQ_ADD, 32'd10);
    send_req(REQ_ADD, 32'd11);
    send_req(REQ_QUERY, '0);
    send_req(REQ_QUERY, 32'd12);
    send_req(REQ_REMOVE, '0);
    send_req(REQ_REMOVE, '0);
    send_req(REQ_REMOVE, '0);
    send_req(REQ_FILTER, '1);
    send_req(REQ_QUERY, VAL_MAX);

    random_chunk(180);
    drain_results();
    write_filter_limit($urandom);
    random_chunk(180);
    drain_results();

    // Phase two: roles swapped.
    send_idle_pct = 84;
    recv_idle_pct = 25;
    write_filter_limit(VAL_MAX);
    random_chunk(180);
    drain_results();
    write_filter_limit('0);
    random_chunk(180);
    drain_results();

    // Phase three: no idling. Strip the table down to the lowest value and
    // keep adding it so its count climbs well above one.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_filter_limit(VAL_MIN);
    send_req(REQ_FILTER, $urandom);
    for (int i = 0; i < REPEAT_ADDS; i++) send_req(REQ_ADD, VAL_MIN);
    send_req(REQ_REMOVE, VAL_MIN);
    send_req(REQ_ADD, VAL_MIN);
    send_req(REQ_ADD, VAL_MIN);
    drain_results();
    write_filter_limit($urandom);
    random_chunk(190);
    drain_results();
    write_filter_limit('1);
    random_chunk(190);
    drain_results();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/smt_pkg.sv
sv/smt_cfg.sv
sv/sorted_multiset_table_top.sv
sim/smt_result_checker.sv
sim/tb_sorted_multiset_table_top.sv
